// ----- hw/rtl/mqcr_pkg.sv -----
// Package for the multi-queue cache replacement block.
// Holds sizes, codes, controller/datapath interface types and the level function.
// No dependencies.
`default_nettype none
package mqcr_pkg;

   localparam int ENTRIES    = 32;
   localparam int IDX_W      = 5;
   localparam int LINK_W     = 6;
   localparam int MAX_QUEUES = 32;
   localparam int LVL_W      = 5;
   localparam int QC_W       = 6;
   localparam int ADDR_W     = 3;

   localparam logic [LINK_W-1:0] NIL       = 6'd32;
   localparam logic [QC_W-1:0]   QC_RESET  = 6'd8;
   localparam logic [QC_W-1:0]   QC_MAX    = 6'd32;
   localparam logic [31:0]       CAP_RESET = 32'd65536;

   localparam logic [1:0] CMD_ACCESS = 2'd0;
   localparam logic [1:0] CMD_PEEK   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_ABSENT    = 2'd2;

   localparam logic KIND_FINAL = 1'b0;
   localparam logic KIND_EVICT = 1'b1;

   localparam logic REG_QUEUE_COUNT = 1'b0;
   localparam logic REG_CAPACITY    = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SCAN, OP_FINAL_LOOK, OP_REMOVE, OP_INC,
      OP_UNLINK, OP_PUSH, OP_EVICT, OP_INSERT, OP_FINAL_MISS
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_INC, S_UNLINK, S_PUSH, S_EVICT
   } state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       found;
      logic [1:0] cmd;
      logic       scan_match;
      logic       scan_last;
      logic       too_large;
      logic       evict_go;
      logic       free_avail;
   } dp_stat_type;

   function automatic logic [LVL_W-1:0] level_of(input logic [31:0] cnt,
                                                 input logic [QC_W-1:0] qc);
      logic [LVL_W-1:0] msb;
      logic [QC_W-1:0]  eff;
      logic [LVL_W-1:0] top;
      msb = '0;
      for (int b = 0; b < 32; b++) begin
         if (cnt[b]) begin
            msb = LVL_W'(b);
         end
      end
      if (qc == '0) begin
         eff = 6'd1;
      end else if (qc > QC_MAX) begin
         eff = QC_MAX;
      end else begin
         eff = qc;
      end
      top = LVL_W'(eff - 6'd1);
      return (msb < top) ? msb : top;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/multi_queue_cache_replacement.sv -----
// Top level of the multi-queue cache replacement block: register port,
// controller and datapath. Depends on mqcr_pkg, mqcr_ctrl, mqcr_dpath.
//
// Usage:
//   Input channel: drive req_cmd, req_obj_id, req_obj_size with start high;
//   the item is taken at a clock edge where start is high and busy is low.
//   Result channel: each result shows for one cycle with rsp_valid high.
//   An access miss gives one eviction notice per evicted object (kind 1),
//   then one final result (last 1); every other command gives one result.
//   An item runs a load step, then a key scan of one table entry per cycle
//   (ends at the first match or at the last entry), a decide step, then:
//   peek, remove and too-large finish there; a hit runs increment, unlink
//   and push; a miss evicts objects one at a time, then inserts and pushes.
//   One item is in work at a time; busy stays high until the final result
//   is registered, and the next item may be taken in the cycle it shows.
//   The receiver cannot stall; results must be taken as they appear.
//   Register port: queue_count at byte address 0, capacity_bytes at 4;
//   write only while busy is low. Reset empties the table and queues and
//   restores the register defaults (8 queues, 65536 bytes).
`default_nettype none
module multi_queue_cache_replacement import mqcr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [63:0]       req_obj_id,
   input  wire logic [31:0]       req_obj_size,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic                   rsp_hit,
   output logic [63:0]            rsp_result_id,
   output logic [LVL_W-1:0]       rsp_queue_level,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [QC_W-1:0] qc_ff;
   logic [31:0]     cap_ff;
   logic            wr_en;
   dp_cmd_type      dcmd;
   dp_stat_type     stat;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         qc_ff  <= QC_RESET;
         cap_ff <= CAP_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_QUEUE_COUNT) begin
            qc_ff <= pwdata[QC_W-1:0];
         end else begin
            cap_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == REG_QUEUE_COUNT) ? {26'd0, qc_ff} : cap_ff;

   mqcr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .dcmd  (dcmd)
   );

   mqcr_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .dcmd            (dcmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_obj_id      (req_obj_id),
      .req_obj_size    (req_obj_size),
      .cfg_queue_count (qc_ff),
      .cfg_capacity    (cap_ff),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_hit         (rsp_hit),
      .rsp_result_id   (rsp_result_id),
      .rsp_queue_level (rsp_queue_level),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/mqcr_ctrl.sv -----
// Controller state machine for the multi-queue cache replacement block.
// Sequences datapath operations; depends on mqcr_pkg.
`default_nettype none
module mqcr_ctrl import mqcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire dp_stat_type stat,
   output dp_cmd_type       dcmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dcmd.op  = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dcmd.op  = OP_LOAD;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            dcmd.op = OP_SCAN;
            if (stat.scan_match || stat.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (stat.cmd)
               CMD_REMOVE: begin
                  dcmd.op  = stat.found ? OP_REMOVE : OP_FINAL_LOOK;
                  state_in = S_IDLE;
               end
               CMD_ACCESS: begin
                  if (stat.found) begin
                     state_in = S_INC;
                  end else if (stat.too_large) begin
                     dcmd.op  = OP_FINAL_LOOK;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_EVICT;
                  end
               end
               default: begin
                  dcmd.op  = OP_FINAL_LOOK;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INC: begin
            dcmd.op  = OP_INC;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            dcmd.op  = OP_UNLINK;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            dcmd.op  = OP_PUSH;
            state_in = S_IDLE;
         end
         S_EVICT: begin
            if (stat.evict_go) begin
               dcmd.op = OP_EVICT;
            end else if (stat.free_avail) begin
               dcmd.op  = OP_INSERT;
               state_in = S_PUSH;
            end else begin
               dcmd.op  = OP_FINAL_MISS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/mqcr_dpath.sv -----
// Datapath for the multi-queue cache replacement block: object table, queue
// lists, byte counters and result register. Depends on mqcr_pkg.
`default_nettype none
module mqcr_dpath import mqcr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        dcmd,
   output dp_stat_type            stat,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [63:0]       req_obj_id,
   input  wire logic [31:0]       req_obj_size,
   input  wire logic [QC_W-1:0]   cfg_queue_count,
   input  wire logic [31:0]       cfg_capacity,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic                   rsp_hit,
   output logic [63:0]            rsp_result_id,
   output logic [LVL_W-1:0]       rsp_queue_level,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   logic [1:0]        cmd_ff;
   logic [63:0]       id_ff;
   logic [31:0]       size_ff;
   logic [IDX_W-1:0]  scan_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  e_ff;
   logic [LVL_W-1:0]  nl_ff;
   logic [31:0]       occ_ff;
   logic [ENTRIES-1:0] valid_ff;

   logic [63:0]       key_ff    [ENTRIES];
   logic [31:0]       bytes_ff  [ENTRIES];
   logic [31:0]       count_ff  [ENTRIES];
   logic [LVL_W-1:0]  level_ff  [ENTRIES];
   logic [LINK_W-1:0] prev_ff   [ENTRIES];
   logic [LINK_W-1:0] next_ff   [ENTRIES];
   logic [LINK_W-1:0] head_ff   [MAX_QUEUES];
   logic [LINK_W-1:0] tail_ff   [MAX_QUEUES];
   logic [LINK_W-1:0] qobj_ff   [MAX_QUEUES];
   logic [31:0]       qbytes_ff [MAX_QUEUES];

   logic              rsp_valid_ff, rsp_kind_ff, rsp_hit_ff, rsp_last_ff;
   logic [63:0]       rsp_id_ff;
   logic [LVL_W-1:0]  rsp_lvl_ff;
   logic [1:0]        rsp_status_ff;

   logic [IDX_W-1:0]  victim, free_idx, unl_idx;
   logic              victim_ok, over;
   logic [32:0]       need_sum;
   logic [LVL_W-1:0]  u_q, push_q;
   logic [LINK_W-1:0] u_p, u_n, push_h;
   logic [31:0]       u_bytes, inc_cnt;
   logic              do_unlink, do_free;

   always_comb begin
      victim    = '0;
      victim_ok = 1'b0;
      for (int q = MAX_QUEUES - 1; q >= 0; q--) begin
         if (!tail_ff[q][LINK_W-1]) begin
            victim    = tail_ff[q][IDX_W-1:0];
            victim_ok = 1'b1;
         end
      end
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign need_sum = {1'b0, occ_ff} + {1'b0, size_ff};
   assign over     = need_sum > {1'b0, cfg_capacity};

   assign unl_idx   = (dcmd.op == OP_EVICT) ? victim : e_ff;
   assign u_q       = level_ff[unl_idx];
   assign u_p       = prev_ff[unl_idx];
   assign u_n       = next_ff[unl_idx];
   assign u_bytes   = bytes_ff[unl_idx];
   assign push_q    = found_ff ? nl_ff : '0;
   assign push_h    = head_ff[push_q];
   assign inc_cnt   = (count_ff[e_ff] == 32'hFFFF_FFFF) ? count_ff[e_ff]
                                                        : count_ff[e_ff] + 32'd1;
   assign do_free   = (dcmd.op == OP_REMOVE) || (dcmd.op == OP_EVICT);
   assign do_unlink = do_free || (dcmd.op == OP_UNLINK);

   assign stat.found      = found_ff;
   assign stat.cmd        = cmd_ff;
   assign stat.scan_match = valid_ff[scan_ff] && (key_ff[scan_ff] == id_ff);
   assign stat.scan_last  = (scan_ff == IDX_W'(ENTRIES - 1));
   assign stat.too_large  = size_ff > cfg_capacity;
   assign stat.evict_go   = (over || (&valid_ff)) && victim_ok;
   assign stat.free_avail = ~(&valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < MAX_QUEUES; q++) begin
            head_ff[q]   <= NIL;
            tail_ff[q]   <= NIL;
            qobj_ff[q]   <= '0;
            qbytes_ff[q] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;

         if (dcmd.op == OP_LOAD) begin
            cmd_ff   <= req_cmd;
            id_ff    <= req_obj_id;
            size_ff  <= req_obj_size;
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end

         if (dcmd.op == OP_SCAN) begin
            if (stat.scan_match) begin
               found_ff <= 1'b1;
               e_ff     <= scan_ff;
            end
            scan_ff <= scan_ff + IDX_W'(1);
         end

         if (dcmd.op == OP_INC) begin
            count_ff[e_ff] <= inc_cnt;
            nl_ff          <= level_of(inc_cnt, cfg_queue_count);
         end

         if (do_unlink) begin
            if (!u_p[LINK_W-1]) begin
               next_ff[u_p[IDX_W-1:0]] <= u_n;
            end else begin
               head_ff[u_q] <= u_n;
            end
            if (!u_n[LINK_W-1]) begin
               prev_ff[u_n[IDX_W-1:0]] <= u_p;
            end else begin
               tail_ff[u_q] <= u_p;
            end
            qobj_ff[u_q]   <= qobj_ff[u_q] - LINK_W'(1);
            qbytes_ff[u_q] <= qbytes_ff[u_q] - u_bytes;
         end

         if (do_free) begin
            valid_ff[unl_idx] <= 1'b0;
            occ_ff            <= occ_ff - u_bytes;
         end

         if (dcmd.op == OP_INSERT) begin
            valid_ff[free_idx] <= 1'b1;
            key_ff[free_idx]   <= id_ff;
            bytes_ff[free_idx] <= size_ff;
            count_ff[free_idx] <= 32'd1;
            occ_ff             <= occ_ff + size_ff;
            e_ff               <= free_idx;
         end

         if (dcmd.op == OP_PUSH) begin
            prev_ff[e_ff] <= NIL;
            next_ff[e_ff] <= push_h;
            if (!push_h[LINK_W-1]) begin
               prev_ff[push_h[IDX_W-1:0]] <= {1'b0, e_ff};
            end else begin
               tail_ff[push_q] <= {1'b0, e_ff};
            end
            head_ff[push_q]   <= {1'b0, e_ff};
            level_ff[e_ff]    <= push_q;
            qobj_ff[push_q]   <= qobj_ff[push_q] + LINK_W'(1);
            qbytes_ff[push_q] <= qbytes_ff[push_q] + bytes_ff[e_ff];
         end

         case (dcmd.op)
            OP_FINAL_LOOK: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= KIND_FINAL;
               rsp_id_ff    <= id_ff;
               rsp_last_ff  <= 1'b1;
               if (cmd_ff == CMD_REMOVE) begin
                  rsp_hit_ff    <= 1'b0;
                  rsp_lvl_ff    <= '0;
                  rsp_status_ff <= ST_ABSENT;
               end else if (cmd_ff == CMD_ACCESS) begin
                  rsp_hit_ff    <= 1'b0;
                  rsp_lvl_ff    <= '0;
                  rsp_status_ff <= ST_TOO_LARGE;
               end else begin
                  rsp_hit_ff    <= found_ff;
                  rsp_lvl_ff    <= found_ff ? level_ff[e_ff] : '0;
                  rsp_status_ff <= ST_OK;
               end
            end
            OP_REMOVE: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= KIND_FINAL;
               rsp_hit_ff    <= 1'b1;
               rsp_id_ff     <= id_ff;
               rsp_lvl_ff    <= u_q;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= 1'b1;
            end
            OP_EVICT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= KIND_EVICT;
               rsp_hit_ff    <= 1'b0;
               rsp_id_ff     <= key_ff[victim];
               rsp_lvl_ff    <= u_q;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= 1'b0;
            end
            OP_PUSH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= KIND_FINAL;
               rsp_hit_ff    <= found_ff;
               rsp_id_ff     <= id_ff;
               rsp_lvl_ff    <= push_q;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= 1'b1;
            end
            OP_FINAL_MISS: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= KIND_FINAL;
               rsp_hit_ff    <= 1'b0;
               rsp_id_ff     <= id_ff;
               rsp_lvl_ff    <= '0;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_queue_level = rsp_lvl_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/mqcr_checker.sv -----
// Port-level checks for the multi-queue cache replacement block, bound to
// its top level. Depends on mqcr_pkg.
`default_nettype none
module mqcr_checker import mqcr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [1:0]        req_cmd,
   input wire logic [63:0]       req_obj_id,
   input wire logic [31:0]       req_obj_size,
   input wire logic              rsp_valid,
   input wire logic              rsp_kind,
   input wire logic              rsp_hit,
   input wire logic [63:0]       rsp_result_id,
   input wire logic [LVL_W-1:0]  rsp_queue_level,
   input wire logic [1:0]        rsp_status,
   input wire logic              rsp_last,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [ADDR_W-1:0] paddr,
   input wire logic [31:0]       pwdata,
   input wire logic [31:0]       prdata,
   input wire logic              pready
);

   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_EVICT) == !rsp_last)
      else $error("notice and last flag disagree");

   a_notice_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EVICT) |-> !rsp_hit && (rsp_status == ST_OK))
      else $error("eviction notice with hit or status set");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_notice_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("eviction notice outside an item");

   a_final_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after a final result");

endmodule

bind multi_queue_cache_replacement mqcr_checker u_mqcr_checker (.*);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench for the multi-queue cache replacement block.
// Predicts access/peek/remove results and eviction notices from its own table model.
// Depends on mqcr_pkg and multi_queue_cache_replacement.
`default_nettype none
module testbench import mqcr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic        hit;
      logic [63:0] id;
      logic [4:0]  level;
      logic [1:0]  status;
      logic        last;
   } mq_result_type;

   logic clock, reset, start, busy;
   logic [1:0] req_cmd;
   logic [63:0] req_obj_id;
   logic [31:0] req_obj_size;
   logic rsp_valid, rsp_kind, rsp_hit, rsp_last;
   logic [63:0] rsp_result_id;
   logic [4:0] rsp_queue_level;
   logic [1:0] rsp_status;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   multi_queue_cache_replacement uut (.*);

   // predictor state
   logic [5:0]  mq_qcount;
   logic [31:0] mq_capacity;
   logic        slot_valid [ENTRIES];
   logic [63:0] slot_key [ENTRIES];
   logic [31:0] slot_bytes [ENTRIES];
   logic [31:0] slot_count [ENTRIES];
   logic [4:0]  slot_level [ENTRIES];
   int          slot_prev [ENTRIES];
   int          slot_next [ENTRIES];
   int          q_head [MAX_QUEUES];
   int          q_tail [MAX_QUEUES];
   logic [31:0] used_bytes;

   mq_result_type pending_results[$];
   int errors = 0, results_seen = 0, evictions_seen = 0, items_sent = 0;
   int idle_pct = 0;
   logic [63:0] id_pool [16];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int find_slot(logic [63:0] id);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_key[i] == id) return i;
      return ENTRIES;
   endfunction

   function automatic int open_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!slot_valid[i]) return i;
      return ENTRIES;
   endfunction

   function automatic logic [4:0] freq_level(logic [31:0] cnt);
      int eff, lv;
      eff = (mq_qcount == 0) ? 1 : (mq_qcount > MAX_QUEUES) ? MAX_QUEUES : mq_qcount;
      lv = 0;
      while (cnt > 1 && lv < eff - 1) begin
         cnt = cnt >> 1;
         lv++;
      end
      return lv[4:0];
   endfunction

   function automatic void unlink_slot(int i);
      int q, p, n;
      q = slot_level[i];
      p = slot_prev[i];
      n = slot_next[i];
      if (p < ENTRIES) slot_next[p] = n; else q_head[q] = n;
      if (n < ENTRIES) slot_prev[n] = p; else q_tail[q] = p;
   endfunction

   function automatic void push_front(int q, int i);
      int h;
      h = q_head[q];
      slot_prev[i] = ENTRIES;
      slot_next[i] = h;
      if (h < ENTRIES) slot_prev[h] = i; else q_tail[q] = i;
      q_head[q] = i;
      slot_level[i] = q[4:0];
   endfunction

   function automatic void predict_request(logic [1:0] cmd, logic [63:0] id,
                                           logic [31:0] size);
      int e, v, n_ev;
      logic [4:0] nl;
      e = find_slot(id);
      n_ev = 0;
      if (cmd == CMD_REMOVE) begin
         if (e == ENTRIES) begin
            pending_results.push_back({KIND_FINAL, 1'b0, id, 5'd0, ST_ABSENT, 1'b1});
         end else begin
            pending_results.push_back({KIND_FINAL, 1'b1, id, slot_level[e], ST_OK, 1'b1});
            unlink_slot(e);
            used_bytes -= slot_bytes[e];
            slot_valid[e] = 0;
         end
         return;
      end
      if (cmd != CMD_ACCESS) begin
         if (e == ENTRIES)
            pending_results.push_back({KIND_FINAL, 1'b0, id, 5'd0, ST_OK, 1'b1});
         else
            pending_results.push_back({KIND_FINAL, 1'b1, id, slot_level[e], ST_OK, 1'b1});
         return;
      end
      if (e != ENTRIES) begin
         if (slot_count[e] != 32'hFFFF_FFFF) slot_count[e]++;
         nl = freq_level(slot_count[e]);
         unlink_slot(e);
         push_front(nl, e);
         pending_results.push_back({KIND_FINAL, 1'b1, id, nl, ST_OK, 1'b1});
         return;
      end
      if (size > mq_capacity) begin
         pending_results.push_back({KIND_FINAL, 1'b0, id, 5'd0, ST_TOO_LARGE, 1'b1});
         return;
      end
      while ({32'd0, used_bytes} + size > {32'd0, mq_capacity} || open_slot() == ENTRIES) begin
         v = ENTRIES;
         for (int q = 0; q < MAX_QUEUES; q++)
            if (q_tail[q] < ENTRIES) begin
               v = q_tail[q];
               break;
            end
         if (v == ENTRIES || n_ev >= ENTRIES) break;
         pending_results.push_back({KIND_EVICT, 1'b0, slot_key[v], slot_level[v], ST_OK, 1'b0});
         n_ev++;
         unlink_slot(v);
         used_bytes -= slot_bytes[v];
         slot_valid[v] = 0;
      end
      e = open_slot();
      if (e < ENTRIES) begin
         slot_valid[e] = 1;
         slot_key[e] = id;
         slot_bytes[e] = size;
         slot_count[e] = 1;
         push_front(0, e);
         used_bytes += size;
      end
      pending_results.push_back({KIND_FINAL, 1'b0, id, 5'd0, ST_OK, 1'b1});
   endfunction

   always @(posedge clock) begin
      mq_result_type exp_r;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_kind == KIND_EVICT) evictions_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result id %h", rsp_result_id);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_kind !== exp_r.kind) begin
               $error("kind exp %0d got %0d", exp_r.kind, rsp_kind); errors++;
            end
            if (rsp_hit !== exp_r.hit) begin
               $error("hit exp %0d got %0d", exp_r.hit, rsp_hit); errors++;
            end
            if (rsp_result_id !== exp_r.id) begin
               $error("result_id exp %h got %h", exp_r.id, rsp_result_id); errors++;
            end
            if (rsp_queue_level !== exp_r.level) begin
               $error("queue_level exp %0d got %0d", exp_r.level, rsp_queue_level);
               errors++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_status); errors++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, rsp_last); errors++;
            end
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [63:0] id, logic [31:0] size);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_obj_id <= id;
      req_obj_size <= size;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_request(cmd, id, size);
      items_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      drain();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_W'(4 * REG_CAPACITY)) mq_capacity = data;
      else mq_qcount = data[5:0];
   endtask

   function automatic logic [63:0] pick_id();
      return id_pool[$urandom_range(15)];
   endfunction

   task automatic test_directed();
      send_item(CMD_PEEK, 64'd0, 32'd1);
      send_item(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
      send_item(CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ACCESS, 64'd0, 32'd1);
      send_item(CMD_ACCESS, 64'd0, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) send_item(CMD_ACCESS, 64'd7, 32'd100);
      send_item(CMD_PEEK, 64'd7, 32'd5);
      send_item(2'd3, 64'd7, 32'd5);
      send_item(2'd3, 64'd99, 32'd5);
      send_item(CMD_ACCESS, 64'd8, 32'd65536);
      send_item(CMD_REMOVE, 64'd8, 32'd1);
      send_item(CMD_REMOVE, 64'd8, 32'd1);
      for (int i = 0; i < 6; i++)
         send_item(CMD_ACCESS, 64'h5555_0000_0000_0000 | i, 32'h0000_8000);
   endtask

   task automatic test_slot_pressure();
      csr_write(ADDR_W'(4 * REG_CAPACITY), 32'hFFFF_FFFF);
      csr_write(ADDR_W'(4 * REG_QUEUE_COUNT), 32'd32);
      for (int i = 0; i < 40; i++)
         send_item(CMD_ACCESS, {$urandom, $urandom} | 64'h1, $urandom);
   endtask

   task automatic test_random(int n);
      logic [1:0] cmd;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         cmd = (r < 70) ? CMD_ACCESS : (r < 82) ? CMD_PEEK : (r < 96) ? CMD_REMOVE : 2'd3;
         if ($urandom_range(9) == 0)
            send_item(cmd, {$urandom, $urandom}, $urandom);
         else
            send_item(cmd, pick_id(), $urandom_range(1, mq_capacity / 6 + 1));
      end
   endtask

   task automatic test_settings();
      logic [31:0] caps [4] = '{32'd1, 32'd300, 32'd4096, 32'hFFFF_FFFF};
      logic [31:0] qcs [5] = '{32'd0, 32'd1, 32'd3, 32'd40, 32'd63};
      for (int k = 0; k < 16; k++) id_pool[k] = {$urandom, $urandom};
      for (int p = 0; p < 8; p++) begin
         idle_pct = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 67 : (p % 4 == 2) ? 18 : 0;
         csr_write(ADDR_W'(4 * REG_QUEUE_COUNT), qcs[p % 5]);
         csr_write(ADDR_W'(4 * REG_CAPACITY), caps[p % 4]);
         test_random(44);
      end
      idle_pct = 0;
   endtask

   initial begin
      reset = 1'b1; start = 1'b0; req_cmd = '0; req_obj_id = '0; req_obj_size = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      mq_qcount = QC_RESET;
      mq_capacity = CAP_RESET;
      used_bytes = 0;
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 0;
      for (int q = 0; q < MAX_QUEUES; q++) begin
         q_head[q] = ENTRIES;
         q_tail[q] = ENTRIES;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_slot_pressure();
      test_settings();
      drain();
      $display("Sent %0d items; checked %0d results including %0d evictions.",
               items_sent, results_seen, evictions_seen);
      if (errors == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/mqcr_pkg.sv
hw/rtl/mqcr_ctrl.sv
hw/rtl/mqcr_dpath.sv
hw/rtl/multi_queue_cache_replacement.sv
hw/rtl/mqcr_checker.sv
sim/testbench.sv
